// ===== sv/multicart_latch_bank_mapper_assert.svh =====
// assertion macros shared by the checker of the multicart latch bank mapper
// no dependencies; included by the checker file
`ifndef MULTICART_LATCH_BANK_MAPPER_ASSERT_SVH
`define MULTICART_LATCH_BANK_MAPPER_ASSERT_SVH

// same-cycle implication, off during reset
`define MLBM_CHECK(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("mlbm check failed");

// next-cycle implication, off during reset
`define MLBM_CHECK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("mlbm next-cycle check failed");

// what must hold in the cycle after reset is asserted
`define MLBM_CHECK_RST(lbl, ck, rn, cons) \
  lbl: assert property (@(posedge ck) !(rn) |=> (cons)) \
    else $error("mlbm reset check failed");

`endif

// ===== sv/mlbm_pkg.sv =====
// shared types and constants for the multicart latch bank mapper
// no dependencies; imported by every module of the block
package mlbm_pkg;

  localparam int BANK_BITS_DEF = 8;

  // board variants
  localparam logic VARIANT_DATA = 1'b0;
  localparam logic VARIANT_ADDR = 1'b1;

  // 4 KiB page codes (address bits 15:12) used by the address-driven rules
  localparam logic [3:0] PAGE_A = 4'hA;
  localparam logic [3:0] PAGE_C = 4'hC;
  localparam logic [3:0] PAGE_D = 4'hD;
  localparam logic [3:0] PAGE_E = 4'hE;

  // mapping after reset: window 0 ram, banks 0,1,0,1 (bit w is lsb of bank w)
  localparam logic [3:0] RST_RAM      = 4'b0001;
  localparam logic [3:0] RST_BANK_LSB = 4'b1010;

  typedef struct packed {
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
  } mlbm_in_t;

  typedef struct packed {
    logic [7:0] window0_bank;
    logic [7:0] window1_bank;
    logic [7:0] window2_bank;
    logic [7:0] window3_bank;
    logic       window0_is_ram;
    logic       window1_is_ram;
    logic       window2_is_ram;
    logic       window3_is_ram;
    logic       mirror_horizontal;
    logic       latch_taken;
  } mlbm_out_t;

endpackage

// ===== sv/mlbm_remap.sv =====
// window mapping rules: latch contents and variant to four window mappings
// depends on mlbm_pkg; used by multicart_latch_bank_mapper
module mlbm_remap #(
  parameter int BANK_BITS = mlbm_pkg::BANK_BITS_DEF
) (
  input  logic                       variant,
  input  logic [15:0]                addr,
  input  logic [7:0]                 data,
  input  logic [BANK_BITS-1:0]       bank3_prev,
  input  logic                       ram3_prev,
  output logic [3:0][BANK_BITS-1:0]  bank,
  output logic [3:0]                 ram,
  output logic                       mirror
);
  import mlbm_pkg::*;

  logic [3:0][15:0] b;
  logic [3:0]       r;
  logic [1:0]       rw;
  logic             use_rw;
  logic [15:0]      ae;
  logic [15:0]      ao;
  logic [15:0]      q;

  assign ae = {addr[15:1], 1'b0};
  assign ao = {addr[15:1], 1'b1};
  assign q  = {1'b0, addr[15:2], 1'b0};

  always_comb begin
    b      = '0;
    r      = '0;
    b[3]   = 16'(bank3_prev);
    r[3]   = ram3_prev;
    use_rw = 1'b1;
    rw     = data[5:4];
    mirror = data[0];
    if (variant == VARIANT_DATA) begin
      if (data[1]) begin
        for (int w = 0; w < 4; w++) begin
          b[w] = {1'b0, addr[15:1]};
          r[w] = 1'b0;
        end
        // extra ram window opposite the main one
        b[rw ^ 2'b10] = '0;
        r[rw ^ 2'b10] = 1'b1;
      end else if (data[3]) begin
        b[0] = q;
        b[1] = q | 16'h0001;
        b[2] = q | 16'h0002;
        b[3] = q | {12'h000, data[2] & data[6], data[2], 2'b11};
        r    = '0;
      end else begin
        b[0] = q;
        b[1] = q | 16'h0001;
        b[2] = 16'h0000;
        b[3] = 16'h0001;
        r    = '0;
      end
    end else begin
      rw     = addr[10:9];
      mirror = addr[11];
      unique case (addr[15:12])
        PAGE_A: begin
          // window 3 keeps its previous mapping unless rw makes it the ram window
          b[0]   = ae;
          b[1]   = ao;
          b[2]   = 16'h0000;
          r[2:0] = 3'b000;
        end
        PAGE_C: begin
          b[0] = ae;
          b[1] = ao;
          b[2] = ae | 16'h0002;
          b[3] = ao | 16'h0002;
          r    = '0;
        end
        PAGE_D: begin
          for (int w = 0; w < 4; w++) begin
            b[w] = addr;
          end
          r                    = '0;
          use_rw               = 1'b0;
          b[{1'b0, addr[9]}]   = '0;
          r[{1'b0, addr[9]}]   = 1'b1;
          b[{1'b1, addr[9]}]   = '0;
          r[{1'b1, addr[9]}]   = 1'b1;
        end
        PAGE_E: begin
          b[0] = ae;
          b[1] = ao;
          b[2] = addr[8] ? (ae | 16'h000E) : 16'h0000;
          b[3] = addr[8] ? (ao | 16'h000E) : 16'h0001;
          r    = '0;
        end
        default: begin
          b[0]   = ae;
          b[1]   = ao;
          b[2]   = 16'h0000;
          b[3]   = 16'h0001;
          r      = '0;
          use_rw = 1'b0;
        end
      endcase
    end
    if (use_rw) begin
      b[rw] = '0;
      r[rw] = 1'b1;
    end
    for (int w = 0; w < 4; w++) begin
      bank[w] = b[w][BANK_BITS-1:0];
    end
    ram = r;
  end

endmodule

// ===== sv/multicart_latch_bank_mapper.sv =====
// top level of the multicart latch bank mapper: input and result registers,
// latch and mapping state; depends on mlbm_pkg and mlbm_remap
//
// usage:
//   in_*  : one cpu write word (address, data) per valid/ready handshake
//   out_* : one result word per write: all four window mappings, the
//           mirroring and whether the write was latched
//   cfg_* : board variant, written with cfg_wr_en while the block is idle;
//           the mapping is recomputed from the current latch on that edge
// each write passes through the input register, then the result register,
//   before its result is presented
// throughput: one write per cycle while results are taken; the latch test
//   for a write uses the mapping left by the write before it, which the
//   single remap stage produces in the same cycle it registers the result
// a stalled result holds in the result register while one more write
//   waits in the input register; in_ready drops only when both are full
// reset (rst_n low, synchronous) empties both registers, selects the
//   data-driven variant, clears the latch and maps window 0 to ram with
//   rom banks 0,1,0,1 in the four windows
module multicart_latch_bank_mapper #(
  parameter int BANK_BITS = mlbm_pkg::BANK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mlbm_pkg::mlbm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mlbm_pkg::mlbm_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import mlbm_pkg::*;

  logic                      in_vld_r;
  mlbm_in_t                  in_data_r;
  logic                      out_vld_r;
  mlbm_out_t                 out_data_r;
  logic                      variant_r;
  logic [15:0]               lat_addr_r;
  logic [7:0]                lat_byte_r;
  logic [3:0][BANK_BITS-1:0] bank_r;
  logic [3:0]                ram_r;
  logic                      mirror_r;

  logic                      adv;
  logic                      take;
  logic                      rm_variant;
  logic [15:0]               rm_addr;
  logic [7:0]                rm_data;
  logic [3:0][BANK_BITS-1:0] rm_bank;
  logic [3:0]                rm_ram;
  logic                      rm_mirror;
  logic [3:0][BANK_BITS-1:0] res_bank;
  logic [3:0]                res_ram;
  logic                      res_mirror;
  logic [3:0][15:0]          res_ext;
  mlbm_out_t                 res;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  // writes below cartridge space, below $a000 on the address variant, or
  // into a ram window leave the latch alone
  assign take = in_data_r.cpu_address[15]
             && !(variant_r == VARIANT_ADDR && in_data_r.cpu_address[14:13] == 2'b00)
             && !ram_r[in_data_r.cpu_address[14:13]];

  // a variant write reuses the remap logic on the current latch
  assign rm_variant = cfg_wr_en ? cfg_wr_data : variant_r;
  assign rm_addr    = cfg_wr_en ? lat_addr_r : in_data_r.cpu_address;
  assign rm_data    = cfg_wr_en ? lat_byte_r : in_data_r.write_data;

  mlbm_remap #(
    .BANK_BITS (BANK_BITS)
  ) u_remap (
    .variant    (rm_variant),
    .addr       (rm_addr),
    .data       (rm_data),
    .bank3_prev (bank_r[3]),
    .ram3_prev  (ram_r[3]),
    .bank       (rm_bank),
    .ram        (rm_ram),
    .mirror     (rm_mirror)
  );

  assign res_bank   = take ? rm_bank : bank_r;
  assign res_ram    = take ? rm_ram : ram_r;
  assign res_mirror = take ? rm_mirror : mirror_r;

  always_comb begin
    for (int w = 0; w < 4; w++) begin
      res_ext[w] = 16'(res_bank[w]);
    end
    res.window0_bank      = res_ext[0][7:0];
    res.window1_bank      = res_ext[1][7:0];
    res.window2_bank      = res_ext[2][7:0];
    res.window3_bank      = res_ext[3][7:0];
    res.window0_is_ram    = res_ram[0];
    res.window1_is_ram    = res_ram[1];
    res.window2_is_ram    = res_ram[2];
    res.window3_is_ram    = res_ram[3];
    res.mirror_horizontal = res_mirror;
    res.latch_taken       = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      variant_r  <= VARIANT_DATA;
      lat_addr_r <= '0;
      lat_byte_r <= '0;
      ram_r      <= RST_RAM;
      mirror_r   <= 1'b0;
      for (int w = 0; w < 4; w++) begin
        bank_r[w] <= BANK_BITS'(RST_BANK_LSB[w]);
      end
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        variant_r <= cfg_wr_data;
        bank_r    <= rm_bank;
        ram_r     <= rm_ram;
        mirror_r  <= rm_mirror;
      end else if (adv && take) begin
        lat_addr_r <= in_data_r.cpu_address;
        lat_byte_r <= in_data_r.write_data;
        bank_r     <= rm_bank;
        ram_r      <= rm_ram;
        mirror_r   <= rm_mirror;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/multicart_latch_bank_mapper_checker.sv =====
// port-level checker for the multicart latch bank mapper, bound to the top
// depends on mlbm_pkg and multicart_latch_bank_mapper_assert.svh
`include "multicart_latch_bank_mapper_assert.svh"

module mlbm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input mlbm_pkg::mlbm_out_t out_data
);
  import mlbm_pkg::*;

  // a ram window always reports bank zero
  `MLBM_CHECK(a_ram_bank_zero, clk, rst_n, out_valid, (!out_data.window0_is_ram || out_data.window0_bank == 8'd0) && (!out_data.window1_is_ram || out_data.window1_bank == 8'd0) && (!out_data.window2_is_ram || out_data.window2_bank == 8'd0) && (!out_data.window3_is_ram || out_data.window3_bank == 8'd0))

  // no rule leaves more than two ram windows
  `MLBM_CHECK(a_ram_count, clk, rst_n, out_valid, $countones({out_data.window0_is_ram, out_data.window1_is_ram, out_data.window2_is_ram, out_data.window3_is_ram}) <= 2)

  // stalled word holds
  `MLBM_CHECK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  `MLBM_CHECK_RST(a_rst_empty, clk, rst_n, !out_valid)

endmodule

bind multicart_latch_bank_mapper mlbm_checker u_mlbm_checker (.*);

// ===== tb/sv/multicart_latch_bank_mapper_chk.sv =====
// checker for the multicart latch bank mapper: watches the write, result and
// variant ports, predicts each result word and compares it field by field
// depends on mlbm_pkg
module multicart_latch_bank_mapper_chk #(
  parameter int BANK_BITS = mlbm_pkg::BANK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  mlbm_pkg::mlbm_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  mlbm_pkg::mlbm_out_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output int unsigned         mismatches,
  output int unsigned         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlbm_pkg::*;

  localparam logic [31:0] BANK_MASK = (32'd1 << BANK_BITS) - 32'd1;
  // lowest address the address-driven variant will latch
  localparam logic [15:0] ADDR_VARIANT_FLOOR = 16'hA000;

  logic        variant;
  logic [15:0] latch_addr;
  logic [7:0]  latch_byte;
  logic [7:0]  win_bank [4];
  logic        win_ram [4];
  logic        mirror;

  mlbm_out_t   expected_maps [$];
  mlbm_out_t   want;
  int unsigned bad_words = 0;

  assign mismatches = bad_words;

  function automatic void map_rom8(int unsigned w, logic [31:0] b);
    win_bank[w % 4] = 8'(b & BANK_MASK);
    win_ram[w % 4]  = 1'b0;
  endfunction

  // a 16 KiB bank n covers 8 KiB banks 2n and 2n+1
  function automatic void map_rom16(int unsigned w, logic [31:0] n);
    map_rom8(w, n << 1);
    map_rom8(w + 1, (n << 1) | 32'd1);
  endfunction

  function automatic void map_ram8(int unsigned w);
    win_bank[w % 4] = 8'd0;
    win_ram[w % 4]  = 1'b1;
  endfunction

  function automatic void remap_windows();
    logic [31:0] a;
    logic [31:0] d;
    logic [31:0] b;
    int unsigned rw;
    a = 32'(latch_addr);
    d = 32'(latch_byte);
    if (variant == VARIANT_DATA) begin
      rw = (d >> 4) & 3;
      if (d[1]) begin
        for (int w = 0; w < 4; w++) map_rom8(w, a >> 1);
        map_ram8(rw ^ 2);
      end else if (d[3]) begin
        b = (a >> 1) & ~32'd1;
        map_rom8(0, b);
        map_rom8(1, b | 32'd1);
        map_rom8(2, b | 32'd2);
        map_rom8(3, b | 32'd3 | (d & 32'd4) | ((d[2] && d[6]) ? 32'd8 : 32'd0));
      end else begin
        map_rom16(0, a >> 2);
        map_rom16(2, 32'd0);
      end
      map_ram8(rw);
      mirror = d[0];
    end else begin
      rw = (a >> 9) & 3;
      case (latch_addr[15:12])
        PAGE_A: begin
          // window 3 keeps whatever it had unless rw makes it the ram window
          map_rom16(0, a >> 1);
          map_rom8(2, 32'd0);
          map_ram8(rw);
        end
        PAGE_C: begin
          map_rom16(0, a >> 1);
          map_rom16(2, (a >> 1) | 32'd1);
          map_ram8(rw);
        end
        PAGE_D: begin
          for (int w = 0; w < 4; w++) map_rom8(w, a);
          map_ram8(a[9]);
          map_ram8(2 + a[9]);
        end
        PAGE_E: begin
          map_rom16(0, a >> 1);
          map_rom16(2, a[8] ? ((a >> 1) | 32'd7) : 32'd0);
          map_ram8(rw);
        end
        default: begin
          map_rom16(0, a >> 1);
          map_rom16(2, 32'd0);
        end
      endcase
      mirror = a[11];
    end
  endfunction

  function automatic void reset_mapping();
    variant    = VARIANT_DATA;
    latch_addr = '0;
    latch_byte = '0;
    mirror     = 1'b0;
    for (int w = 0; w < 4; w++) begin
      win_bank[w] = '0;
      win_ram[w]  = 1'b0;
    end
    remap_windows();
  endfunction

  function automatic mlbm_out_t predict_write(mlbm_in_t wr);
    logic      take;
    mlbm_out_t r;
    take = 1'b1;
    if (!wr.cpu_address[15]) take = 1'b0;
    else if (variant == VARIANT_ADDR && wr.cpu_address < ADDR_VARIANT_FLOOR) take = 1'b0;
    else if (win_ram[wr.cpu_address[14:13]]) take = 1'b0;
    if (take) begin
      latch_addr = wr.cpu_address;
      latch_byte = wr.write_data;
      remap_windows();
    end
    r.window0_bank      = win_bank[0];
    r.window1_bank      = win_bank[1];
    r.window2_bank      = win_bank[2];
    r.window3_bank      = win_bank[3];
    r.window0_is_ram    = win_ram[0];
    r.window1_is_ram    = win_ram[1];
    r.window2_is_ram    = win_ram[2];
    r.window3_is_ram    = win_ram[3];
    r.mirror_horizontal = mirror;
    r.latch_taken       = take;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      bad_words++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_mapping();
      expected_maps.delete();
    end else begin
      // a result can never belong to a write taken on the same edge
      if (out_valid && out_ready) begin
        if (expected_maps.size() == 0) begin
          $error("result word with no write outstanding");
          bad_words++;
        end else begin
          want = expected_maps.pop_front();
          check_field("window0_bank", want.window0_bank, out_data.window0_bank);
          check_field("window1_bank", want.window1_bank, out_data.window1_bank);
          check_field("window2_bank", want.window2_bank, out_data.window2_bank);
          check_field("window3_bank", want.window3_bank, out_data.window3_bank);
          check_field("window0_is_ram", want.window0_is_ram, out_data.window0_is_ram);
          check_field("window1_is_ram", want.window1_is_ram, out_data.window1_is_ram);
          check_field("window2_is_ram", want.window2_is_ram, out_data.window2_is_ram);
          check_field("window3_is_ram", want.window3_is_ram, out_data.window3_is_ram);
          check_field("mirror_horizontal", want.mirror_horizontal,
                      out_data.mirror_horizontal);
          check_field("latch_taken", want.latch_taken, out_data.latch_taken);
        end
      end
      if (cfg_wr_en) begin
        variant = cfg_wr_data;
        remap_windows();
      end
      if (in_valid && in_ready) expected_maps.push_back(predict_write(in_data));
    end
    pending <= expected_maps.size();
  end

endmodule

// ===== tb/sv/multicart_latch_bank_mapper_tb.sv =====
// testbench top for the multicart latch bank mapper: clock, reset, cpu write
// stimulus, result back-pressure, variant writes and the verdict
// depends on mlbm_pkg, multicart_latch_bank_mapper and its checker
module multicart_latch_bank_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlbm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  mlbm_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  mlbm_out_t   out_data;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        steady = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles = 0;

  multicart_latch_bank_mapper #(
    .BANK_BITS(BANK_BITS_DEF)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  multicart_latch_bank_mapper_chk #(
    .BANK_BITS(BANK_BITS_DEF)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 22);

  // valid stays up between back-to-back words; it only drops for a gap
  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    mlbm_in_t w;
    w.cpu_address = addr;
    w.write_data  = data;
    if (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 22);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off until every result word is back and the block is idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_variant(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n, input bit mid_drain);
    logic [15:0] a;
    logic [3:0]  pg;
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        // below cartridge space
        a = 16'($urandom_range(16'h7fff));
      end else if (roll < 45) begin
        // favor the pages the address-driven rules decode
        case ($urandom_range(3))
          0:       pg = PAGE_A;
          1:       pg = PAGE_C;
          2:       pg = PAGE_D;
          default: pg = PAGE_E;
        endcase
        a = {pg, 12'($urandom)};
      end else begin
        a = {1'b1, 15'($urandom)};
      end
      send_write(a, 8'($urandom));
      if (mid_drain && i == n / 2) settle();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data-driven rules straight out of reset; window 0 starts as ram
    send_write(16'h8000, 8'h00);
    send_write(16'h0000, 8'h00);
    send_write(16'h7fff, 8'hff);
    send_write(16'hA000, 8'h00);
    send_write(16'hFFFF, 8'hFF);
    send_write(16'hC000, 8'h08);
    send_write(16'hA002, 8'h4C);
    send_write(16'hE1FE, 8'h3D);
    send_write(16'hBFFE, 8'h22);

    // address-driven rules, remapped from the current latch on the write
    set_variant(VARIANT_ADDR);
    send_write(16'h9FFF, 8'($urandom));
    send_write(16'hA000, 8'($urandom));
    send_write(16'hA600, 8'($urandom));
    send_write(16'hB800, 8'($urandom));
    send_write(16'hC000, 8'($urandom));
    send_write(16'hCE00, 8'($urandom));
    send_write(16'hD000, 8'($urandom));
    send_write(16'hD200, 8'($urandom));
    send_write(16'hE000, 8'($urandom));
    send_write(16'hE1FF, 8'($urandom));
    send_write(16'hFFFF, 8'($urandom));
    send_write(16'hF800, 8'($urandom));

    set_variant(VARIANT_DATA);
    random_phase(120, 1'b0);
    set_variant(VARIANT_ADDR);
    random_phase(120, 1'b1);
    steady <= 1'b1;
    set_variant(VARIANT_DATA);
    random_phase(120, 1'b0);
    steady <= 1'b0;
    set_variant(VARIANT_ADDR);
    random_phase(120, 1'b0);
    set_variant(VARIANT_ADDR);
    random_phase(120, 1'b0);
    set_variant(VARIANT_DATA);
    random_phase(120, 1'b0);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
